FILE: design/svf2_pkg.sv
package svf2_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int APB_ADDR_WIDTH = 4;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [COEF_WIDTH-1:0] FREQ_COEF_RESET = 16'd44862;
  localparam logic [COEF_WIDTH-1:0] DAMPING_RESET = 16'd32768;

  typedef enum logic [1:0] {
    REG_FREQ_COEF   = 2'd0,
    REG_DAMPING     = 2'd1,
    REG_FILTER_TYPE = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    FT_LOW   = 2'd0,
    FT_BAND  = 2'd1,
    FT_HIGH  = 2'd2,
    FT_NOTCH = 2'd3
  } filter_type_t;

  typedef struct packed {
    logic [COEF_WIDTH-1:0] freq_coef;
    logic [COEF_WIDTH-1:0] damping;
    filter_type_t          filter_type;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DB,
    ST_NOTCH,
    ST_MUL_FB,
    ST_LOW,
    ST_HIGH,
    ST_MUL_FH,
    ST_BAND,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_DB,
    OP_NOTCH,
    OP_MUL_FB,
    OP_LOW,
    OP_HIGH,
    OP_MUL_FH,
    OP_BAND,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic load;
    logic second_pass;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

FILE: design/svf2_if.sv
interface svf2_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           block_last;

  modport source (output valid, output sample_in, output block_last, input ready);
  modport sink (input valid, input sample_in, input block_last, output ready);
endinterface

interface svf2_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           out_last;

  modport source (output valid, output sample_out, output out_last, input ready);
  modport sink (input valid, input sample_out, input out_last, output ready);
endinterface

FILE: design/svf2_cfg.sv
module svf2_cfg
  import svf2_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_coef <= FREQ_COEF_RESET;
      cfg.damping <= DAMPING_RESET;
      cfg.filter_type <= FT_LOW;
    end else if (wr_en) begin
      unique case (index)
        REG_FREQ_COEF:   cfg.freq_coef <= pwdata[COEF_WIDTH-1:0];
        REG_DAMPING:     cfg.damping <= pwdata[COEF_WIDTH-1:0];
        REG_FILTER_TYPE: cfg.filter_type <= filter_type_t'(pwdata[1:0]);
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_FREQ_COEF:   prdata = APB_DATA_WIDTH'(cfg.freq_coef);
      REG_DAMPING:     prdata = APB_DATA_WIDTH'(cfg.damping);
      REG_FILTER_TYPE: prdata = APB_DATA_WIDTH'(cfg.filter_type);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: design/svf2_ctrl.sv
module svf2_ctrl
  import svf2_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   second_pass, second_pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      second_pass <= 1'b0;
    end else begin
      state <= state_next;
      second_pass <= second_pass_next;
    end
  end

  always_comb begin
    state_next = state;
    second_pass_next = second_pass;
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.second_pass = second_pass;
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        second_pass_next = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL_DB;
        end
      end
      ST_MUL_DB: begin
        cmd.op = OP_MUL_DB;
        state_next = ST_NOTCH;
      end
      ST_NOTCH: begin
        cmd.op = OP_NOTCH;
        state_next = ST_MUL_FB;
      end
      ST_MUL_FB: begin
        cmd.op = OP_MUL_FB;
        state_next = ST_LOW;
      end
      ST_LOW: begin
        cmd.op = OP_LOW;
        state_next = ST_HIGH;
      end
      ST_HIGH: begin
        cmd.op = OP_HIGH;
        state_next = ST_MUL_FH;
      end
      ST_MUL_FH: begin
        cmd.op = OP_MUL_FH;
        state_next = ST_BAND;
      end
      ST_BAND: begin
        cmd.op = OP_BAND;
        if (second_pass) begin
          state_next = ST_OUT;
        end else begin
          second_pass_next = 1'b1;
          state_next = ST_MUL_DB;
        end
      end
      ST_OUT: begin
        // wait until the output register frees up
        if (!sts.out_busy) begin
          cmd.op = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: design/svf2_dp.sv
module svf2_dp
  import svf2_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  cmd_t                           cmd,
  output sts_t                           sts,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           block_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           out_last
);

  localparam int FRAC = COEF_WIDTH - 1;
  localparam int PW = STATE_WIDTH + COEF_WIDTH + 1;
  localparam int RW = PW - FRAC;
  localparam int EW = ((STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH) + 3;
  localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (FRAC - 1);
  localparam logic signed [EW-1:0] STATE_MAX = (EW'(1) <<< (STATE_WIDTH - 1)) - EW'(1);
  localparam logic signed [EW-1:0] SAMPLE_MAX = (EW'(1) <<< (SAMPLE_WIDTH - 1)) - EW'(1);

  function automatic logic signed [EW-1:0] clip(input logic signed [EW-1:0] v,
                                                 input logic signed [EW-1:0] lim);
    logic signed [EW-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < ~lim) r = ~lim;
    return r;
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] prev;
  logic signed [SAMPLE_WIDTH-1:0] mid;
  logic                           last_hold;
  logic signed [STATE_WIDTH-1:0]  lowpass, bandpass, notch, highpass;
  logic signed [PW-1:0]           prod;

  logic signed [SAMPLE_WIDTH:0]   mid_sum;
  logic [COEF_WIDTH-1:0]          coef_sel;
  logic signed [STATE_WIDTH-1:0]  opnd_sel;
  logic signed [PW-1:0]           prod_next;
  logic signed [PW-1:0]           prod_rsum;
  logic signed [RW-1:0]           prod_rnd;
  logic signed [EW-1:0]           rnd_ext, x_ext;
  logic signed [EW-1:0]           notch_next, low_next, high_next, band_next;
  logic signed [STATE_WIDTH-1:0]  sel;
  logic signed [STATE_WIDTH-1:0]  half;
  logic signed [EW-1:0]           out_next;

  assign mid_sum = (SAMPLE_WIDTH + 1)'(prev) + (SAMPLE_WIDTH + 1)'(sample_in);

  // shared multiplier operand select
  assign coef_sel = (cmd.op == OP_MUL_DB) ? cfg.damping : cfg.freq_coef;
  assign opnd_sel = (cmd.op == OP_MUL_FH) ? highpass : bandpass;
  assign prod_next = $signed({1'b0, coef_sel}) * opnd_sel;

  // round to the state lsb
  assign prod_rsum = prod + ROUND;
  assign prod_rnd = prod_rsum[PW-1:FRAC];
  assign rnd_ext = EW'(prod_rnd);
  assign x_ext = cmd.second_pass ? EW'(prev) : EW'(mid);

  assign notch_next = clip(x_ext - rnd_ext, STATE_MAX);
  assign low_next = clip(EW'(lowpass) + rnd_ext, STATE_MAX);
  assign high_next = clip(EW'(notch) - EW'(lowpass), STATE_MAX);
  assign band_next = clip(EW'(bandpass) + rnd_ext, STATE_MAX);

  always_comb begin
    unique case (cfg.filter_type)
      FT_LOW:   sel = lowpass;
      FT_BAND:  sel = bandpass;
      FT_HIGH:  sel = highpass;
      FT_NOTCH: sel = notch;
      default:  sel = notch;
    endcase
  end

  assign half = sel >>> 1;
  assign out_next = clip(EW'(half), SAMPLE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      lowpass <= '0;
      bandpass <= '0;
    end else begin
      if (cmd.load) begin
        prev <= sample_in;
      end
      if (cmd.op == OP_LOW) begin
        lowpass <= low_next[STATE_WIDTH-1:0];
      end
      if (cmd.op == OP_BAND) begin
        bandpass <= band_next[STATE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mid <= mid_sum[SAMPLE_WIDTH:1];
      last_hold <= block_last;
    end
    if (cmd.op == OP_MUL_DB || cmd.op == OP_MUL_FB || cmd.op == OP_MUL_FH) begin
      prod <= prod_next;
    end
    if (cmd.op == OP_NOTCH) begin
      notch <= notch_next[STATE_WIDTH-1:0];
    end
    if (cmd.op == OP_HIGH) begin
      highpass <= high_next[STATE_WIDTH-1:0];
    end
    if (cmd.op == OP_OUT) begin
      sample_out <= out_next[SAMPLE_WIDTH-1:0];
      out_last <= last_hold;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

endmodule

FILE: design/state_variable_filter_2x_unit.sv
// Two-times oversampled state variable filter. Each request runs the filter twice,
// first on the average of the previous and current sample, then on the current
// sample, and returns the selected low, band, high or notch output halved and
// saturated. A request is taken in the idle cycle; it then runs seven steps per pass
// through a single shared coefficient multiplier, and an out step writes the result
// to the output register once that register is free. The next request is taken in the
// cycle after the result is written, even if that result is still waiting; a
// result that is still waiting when the next one is ready stalls the block.
// Coefficients are to be written over the APB port only while idle; the block
// itself does not enforce this.
module state_variable_filter_2x_unit
  import svf2_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  svf2_in_if.sink                   din,
  svf2_out_if.source                dout,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  svf2_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  svf2_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  svf2_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .sample_in  (din.sample_in),
    .block_last (din.block_last),
    .out_valid  (dout.valid),
    .out_ready  (dout.ready),
    .sample_out (dout.sample_out),
    .out_last   (dout.out_last)
  );

endmodule

FILE: design/svf2_checker.sv
module svf2_checker
  import svf2_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input logic                           out_last,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [APB_ADDR_WIDTH-1:0]      paddr,
  input logic [APB_DATA_WIDTH-1:0]      pwdata,
  input logic [APB_DATA_WIDTH-1:0]      prdata,
  input logic                           pready
);

  logic in_acc;
  logic freq_wr;

  assign in_acc = in_valid && in_ready;
  assign freq_wr = psel && penable && pwrite && pready && (paddr[3:2] == REG_FREQ_COEF);

  // clean state after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one request at a time, busy after acceptance and still busy at the out step
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready ##14 !in_ready)
    else $error("request accepted while busy");

  // a pending result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(out_last))
    else $error("pending result changed");

  // coefficient readback
  a_readback: assert property (@(posedge clk) disable iff (rst)
    freq_wr |=> (paddr[3:2] != REG_FREQ_COEF) ||
                (prdata[COEF_WIDTH-1:0] == $past(pwdata[COEF_WIDTH-1:0])))
    else $error("freq_coef readback mismatch");

endmodule

bind state_variable_filter_2x_unit svf2_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_svf2_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .sample_out (dout.sample_out),
  .out_last   (dout.out_last),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready)
);

FILE: dv/state_variable_filter_2x_unit_tb.sv
`timescale 1ns / 100ps

module state_variable_filter_2x_unit_tb
  import svf2_pkg::*;
;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W = 24;
  localparam int COEF_FRAC = 15;
  localparam int UNUSED_REG = 3;
  localparam int SETTLE_CYCLES = 40;
  localparam int CHUNK_ITEMS = 70;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } filter_result_t;

  class filter_scoreboard;
    logic [COEF_WIDTH-1:0]     freq_coef;
    logic [COEF_WIDTH-1:0]     damping;
    filter_type_t              ftype;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic signed [STATE_W-1:0]  low_acc;
    logic signed [STATE_W-1:0]  band_acc;
    filter_result_t            expected_q[$];
    int                        errors;
    int                        checked;

    function new();
      freq_coef = FREQ_COEF_RESET;
      damping = DAMPING_RESET;
      ftype = FT_LOW;
      prev_sample = '0;
      low_acc = '0;
      band_acc = '0;
      errors = 0;
      checked = 0;
    endfunction

    function longint sat(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function longint coef_mul(logic [COEF_WIDTH-1:0] c, longint x);
      return (longint'(c) * x + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    function void run_pass(longint x, output longint notch, output longint high);
      longint n;
      longint h;
      n = sat(x - coef_mul(damping, band_acc), STATE_W);
      low_acc = STATE_W'(sat(low_acc + coef_mul(freq_coef, band_acc), STATE_W));
      h = sat(n - low_acc, STATE_W);
      band_acc = STATE_W'(sat(band_acc + coef_mul(freq_coef, h), STATE_W));
      notch = n;
      high = h;
    endfunction

    function void set_reg(int idx, logic [APB_DATA_WIDTH-1:0] data);
      case (idx)
        REG_FREQ_COEF:   freq_coef = data[COEF_WIDTH-1:0];
        REG_DAMPING:     damping = data[COEF_WIDTH-1:0];
        REG_FILTER_TYPE: ftype = filter_type_t'(data[1:0]);
        default: ;
      endcase
    endfunction

    function void note_request(logic signed [SAMPLE_W-1:0] s, logic last);
      longint x;
      longint mid;
      longint notch;
      longint high;
      longint sel;
      filter_result_t r;
      x = s;
      mid = (longint'(prev_sample) + x) >>> 1;
      prev_sample = s;
      run_pass(mid, notch, high);
      run_pass(x, notch, high);
      case (ftype)
        FT_LOW:  sel = low_acc;
        FT_BAND: sel = band_acc;
        FT_HIGH: sel = high;
        default: sel = notch;
      endcase
      r.sample = SAMPLE_W'(sat(sel >>> 1, SAMPLE_W));
      r.last = last;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] s, logic last);
      filter_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: sample_out %0d out_last %0b", s, last);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      checked++;
      if (s !== r.sample) begin
        $error("sample_out: expected %0d, actual %0d", r.sample, s);
        errors++;
      end
      if (last !== r.last) begin
        $error("out_last: expected %0b, actual %0b", r.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  int src_idle_pct;
  int snk_idle_pct;
  int hold_len;
  int n_sent;
  int n_settings;
  filter_scoreboard sb;

  svf2_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) din_if ();
  svf2_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) dout_if ();

  state_variable_filter_2x_unit #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH(STATE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .din(din_if),
    .dout(dout_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver side
  always @(negedge clk) begin
    if (hold_len > 0) begin
      dout_if.ready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      dout_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready)
      sb.check_result(dout_if.sample_out, dout_if.out_last);
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      din_if.valid <= 1'b0;
      @(negedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.sample_in <= s;
    din_if.block_last <= last;
    do @(posedge clk); while (!din_if.ready);
    sb.note_request(s, last);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [APB_DATA_WIDTH-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_WIDTH'(4 * idx);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // let every request drain before touching the registers
  task automatic drain();
    din_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_filter(input logic [COEF_WIDTH-1:0] f, input logic [COEF_WIDTH-1:0] d,
                            input filter_type_t t);
    drain();
    apb_write(REG_FREQ_COEF, ($urandom & 32'hFFFF_0000) | f);
    apb_write(REG_DAMPING, ($urandom & 32'hFFFF_0000) | d);
    apb_write(REG_FILTER_TYPE, ($urandom & ~32'h3) | t);
    n_settings++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      6, 7:    return SAMPLE_W'($urandom_range(4000) - 2000);
      8:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      9:       return SAMPLE_W'($urandom_range(16) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] corners[20];
    logic [COEF_WIDTH-1:0] fq;
    logic [COEF_WIDTH-1:0] dm;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.sample_in = '0;
    din_if.block_last = 1'b0;
    dout_if.ready = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_len = 0;
    n_sent = 0;
    n_settings = 0;
    corners = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1,
                16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sh7FFF, -16'sd1, 16'sd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corner samples at reset coefficients, then unstable and frozen settings
    for (int i = 0; i < 20; i++) begin
      if (i == 8) begin
        set_filter(16'hFFFF, 16'h0000, FT_NOTCH);
        apb_write(UNUSED_REG, $urandom);
      end else if (i == 14) begin
        set_filter(16'hFFFF, 16'h0000, FT_HIGH);
      end else if (i == 17) begin
        set_filter(16'h0000, 16'hFFFF, FT_BAND);
      end
      send_sample(corners[i], i[0]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin fq = FREQ_COEF_RESET; dm = DAMPING_RESET; end
        1: begin fq = 16'hFFFF; dm = 16'h0000; end
        2: begin fq = 16'h0000; dm = 16'hFFFF; end
        3: begin fq = COEF_WIDTH'($urandom_range(44862)); dm = COEF_WIDTH'($urandom); end
        4: begin fq = 16'd1200; dm = 16'hFFFF; end
        default: begin fq = COEF_WIDTH'($urandom); dm = COEF_WIDTH'($urandom); end
      endcase
      for (int mode = 0; mode < 3; mode++) begin
        set_filter(fq, dm, filter_type_t'((ph + mode) % 4));
        if (mode == 0) apb_write(UNUSED_REG, $urandom);
        src_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 68 : 0;
        snk_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 8 : 0;
        if (ph == 1 && mode == 2) hold_len = HOLD_CYCLES;
        for (int i = 0; i < CHUNK_ITEMS; i++) begin
          if (mode == 2 && i == CHUNK_ITEMS / 2) begin
            din_if.valid <= 1'b0;
            while (sb.pending() != 0) @(negedge clk);
          end
          send_sample(pick_sample(), $urandom_range(7) == 0);
        end
      end
    end

    drain();
    $display("%0d samples through %0d coefficient settings, %0d results checked",
             n_sent, n_settings, sb.checked);
    $display("all four filter types, coefficient extremes, saturation and a long output stall");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
